// ===== src/thi_pkg.sv =====
// Shared types, widths and helper functions for the triangle height interpolator.
// Used by every module of the block; has no dependencies.
package thi_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int XW    = PW + 1;
  localparam int MW    = XW;
  localparam int WF    = 16;
  localparam int QB    = 29;
  localparam int NUMW  = MW + WF + 2;
  localparam int DENW  = MW + 1;
  localparam int CMPW  = DENW + QB;
  localparam int WGTW  = QB + 1;
  localparam int UW    = WGTW + 2;
  localparam int PRW   = COORD_WIDTH + UW;
  localparam int ACCW  = PRW + 2;
  localparam int RW    = ACCW - WF;
  localparam int INW   = 11 * COORD_WIDTH;
  localparam int OUTW  = ((COORD_WIDTH + 7) / 8) * 8;

  localparam logic [QB-1:0] WEIGHT_MAX = {QB{1'b1}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DW-1:0]          diff_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [XW-1:0]          cross_t;

  typedef struct packed {
    coord_t ax, ah, az;
    coord_t bx, bh, bz;
    coord_t cx, ch, cz;
    coord_t px, pz;
  } tri_t;

  typedef struct packed {
    logic   hit;
    logic   degen;
    coord_t h0, h1, h2;
  } side_t;

  typedef struct packed {
    cross_t nv;
    cross_t nw;
    cross_t area;
    side_t  side;
  } front_t;

  typedef struct packed {
    logic [QB-1:0] qv, qw;
    logic          satv, satw;
    logic          negv, negw;
    side_t         side;
  } div_out_t;

  function automatic diff_t sx(input coord_t a);
    return {a[COORD_WIDTH-1], a};
  endfunction

  function automatic logic [MW-1:0] mag(input cross_t a);
    logic [MW-1:0] r;
    r = a[XW-1] ? MW'(-a) : MW'(a);
    return r;
  endfunction

endpackage

// ===== src/triangle_height_interpolate_top.sv =====
// 38 register stages in total; the 31-stage divider accounts for most of them.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while the result register waits on out_tready.
// Reset clears all valid bits; the data registers are not reset. Depends on thi_pkg,
// thi_front, thi_div and thi_blend.
module triangle_height_interpolate_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // vert0_x, vert0_h, vert0_z, vert1_x, vert1_h, vert1_z,
  // vert2_x, vert2_h, vert2_z, query_x, query_z
  input  logic [thi_pkg::INW-1:0]   in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // height, zero filled to whole bytes
  output logic [thi_pkg::OUTW-1:0]  out_tdata,
  // inside_res, degenerate
  output logic [1:0]                out_tuser
);
  import thi_pkg::*;

  logic     en;
  tri_t     tri_in;
  logic     f_vld, d_vld, b_vld;
  front_t   f_data;
  div_out_t d_data;
  logic     b_inside, b_degen;
  coord_t   b_height;

  assign en        = !b_vld || out_tready;
  assign in_tready = en;

  assign tri_in.ax = in_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.ah = in_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.az = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.bx = in_tdata[3*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.bh = in_tdata[4*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.bz = in_tdata[5*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.cx = in_tdata[6*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.ch = in_tdata[7*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.cz = in_tdata[8*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.px = in_tdata[9*COORD_WIDTH +: COORD_WIDTH];
  assign tri_in.pz = in_tdata[10*COORD_WIDTH +: COORD_WIDTH];

  thi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_tri    (tri_in),
    .out_valid (f_vld),
    .out_data  (f_data)
  );

  thi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_vld),
    .in_data   (f_data),
    .out_valid (d_vld),
    .out_data  (d_data)
  );

  thi_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d_vld),
    .in_data    (d_data),
    .out_valid  (b_vld),
    .out_inside (b_inside),
    .out_degen  (b_degen),
    .out_height (b_height)
  );

  assign out_tvalid = b_vld;
  assign out_tdata  = OUTW'(unsigned'(b_height));
  assign out_tuser  = {b_degen, b_inside};

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0)
    else $error("degenerate result with nonzero height");

endmodule

// ===== src/thi_front.sv =====
// Front end: coordinate differences, edge products, cross products and the inside and degenerate flags.
// Depends on thi_pkg; three register stages.
module thi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  thi_pkg::tri_t   in_tri,
  output logic            out_valid,
  output thi_pkg::front_t out_data
);
  import thi_pkg::*;

  typedef struct packed {
    diff_t pbx, pbz, abx, abz;
    diff_t pcx, pcz, bcx, bcz;
    diff_t pax, paz, cax, caz;
    diff_t bax, baz;
    side_t side;
  } s1_t;

  typedef struct packed {
    prod_t e1a, e1b, e2a, e2b, e3a, e3b, ara, arb, nwa, nwb;
    side_t side;
  } s2_t;

  logic [2:0] vld_r;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  front_t s3_r, s3_nxt;

  always_comb begin
    s1_nxt.pbx = sx(in_tri.px) - sx(in_tri.bx);
    s1_nxt.pbz = sx(in_tri.pz) - sx(in_tri.bz);
    s1_nxt.abx = sx(in_tri.ax) - sx(in_tri.bx);
    s1_nxt.abz = sx(in_tri.az) - sx(in_tri.bz);
    s1_nxt.pcx = sx(in_tri.px) - sx(in_tri.cx);
    s1_nxt.pcz = sx(in_tri.pz) - sx(in_tri.cz);
    s1_nxt.bcx = sx(in_tri.bx) - sx(in_tri.cx);
    s1_nxt.bcz = sx(in_tri.bz) - sx(in_tri.cz);
    s1_nxt.pax = sx(in_tri.px) - sx(in_tri.ax);
    s1_nxt.paz = sx(in_tri.pz) - sx(in_tri.az);
    s1_nxt.cax = sx(in_tri.cx) - sx(in_tri.ax);
    s1_nxt.caz = sx(in_tri.cz) - sx(in_tri.az);
    s1_nxt.bax = sx(in_tri.bx) - sx(in_tri.ax);
    s1_nxt.baz = sx(in_tri.bz) - sx(in_tri.az);
    s1_nxt.side.hit   = 1'b0;
    s1_nxt.side.degen = 1'b0;
    s1_nxt.side.h0 = in_tri.ah;
    s1_nxt.side.h1 = in_tri.bh;
    s1_nxt.side.h2 = in_tri.ch;
  end

  always_comb begin
    s2_nxt.e1a = PW'(s1_r.pbx) * PW'(s1_r.abz);
    s2_nxt.e1b = PW'(s1_r.abx) * PW'(s1_r.pbz);
    s2_nxt.e2a = PW'(s1_r.pcx) * PW'(s1_r.bcz);
    s2_nxt.e2b = PW'(s1_r.bcx) * PW'(s1_r.pcz);
    s2_nxt.e3a = PW'(s1_r.pax) * PW'(s1_r.caz);
    s2_nxt.e3b = PW'(s1_r.cax) * PW'(s1_r.paz);
    s2_nxt.ara = PW'(s1_r.bax) * PW'(s1_r.caz);
    s2_nxt.arb = PW'(s1_r.cax) * PW'(s1_r.baz);
    s2_nxt.nwa = PW'(s1_r.bax) * PW'(s1_r.paz);
    s2_nxt.nwb = PW'(s1_r.pax) * PW'(s1_r.baz);
    s2_nxt.side = s1_r.side;
  end

  cross_t e1, e2, e3;
  logic   f1, f2, f3;

  always_comb begin
    e1 = XW'(s2_r.e1a) - XW'(s2_r.e1b);
    e2 = XW'(s2_r.e2a) - XW'(s2_r.e2b);
    e3 = XW'(s2_r.e3a) - XW'(s2_r.e3b);
    f1 = e1[XW-1] || (e1 == '0);
    f2 = e2[XW-1] || (e2 == '0);
    f3 = e3[XW-1] || (e3 == '0);
    s3_nxt.nv   = e3;
    s3_nxt.nw   = XW'(s2_r.nwa) - XW'(s2_r.nwb);
    s3_nxt.area = XW'(s2_r.ara) - XW'(s2_r.arb);
    s3_nxt.side = s2_r.side;
    s3_nxt.side.hit   = (f1 == f2) && (f2 == f3);
    s3_nxt.side.degen = (s3_nxt.area == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = vld_r[2];
  assign out_data  = s3_r;

endmodule

// ===== src/thi_div.sv =====
// Two-lane pipelined restoring divider that forms the barycentric weights.
// Depends on thi_pkg; one quotient bit per stage, QB + 2 register stages.
module thi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  thi_pkg::front_t   in_data,
  output logic              out_valid,
  output thi_pkg::div_out_t out_data
);
  import thi_pkg::*;

  typedef struct packed {
    logic [CMPW-1:0] rem;
    logic [QB-1:0]   q;
    logic            sat;
    logic            neg;
  } lane_t;

  typedef struct packed {
    lane_t           v;
    lane_t           w;
    logic [DENW-1:0] den;
    side_t           side;
  } stg_t;

  typedef struct packed {
    logic [MW-1:0] mv, mw, md;
    logic          negv, negw;
    side_t         side;
  } p1_t;

  logic     p1_vld_r;
  p1_t      p1_r, p1_nxt;
  logic     vld_r [0:QB];
  stg_t     stg_r [0:QB];
  stg_t     stg_nxt [0:QB];

  always_comb begin
    p1_nxt.mv   = mag(in_data.nv);
    p1_nxt.mw   = mag(in_data.nw);
    p1_nxt.md   = mag(in_data.area);
    p1_nxt.negv = in_data.nv[XW-1] ^ in_data.area[XW-1];
    p1_nxt.negw = in_data.nw[XW-1] ^ in_data.area[XW-1];
    p1_nxt.side = in_data.side;
  end

  logic [CMPW-1:0] numv, numw, dlim;
  logic [CMPW-1:0] shd [1:QB];

  always_comb begin
    numv = (CMPW'(p1_r.mv) << (WF + 1)) + CMPW'(p1_r.md);
    numw = (CMPW'(p1_r.mw) << (WF + 1)) + CMPW'(p1_r.md);
    dlim = CMPW'(p1_r.md) << (QB + 1);
    stg_nxt[0].den   = DENW'(p1_r.md) << 1;
    stg_nxt[0].side  = p1_r.side;
    stg_nxt[0].v.rem = numv;
    stg_nxt[0].v.q   = '0;
    stg_nxt[0].v.sat = (numv >= dlim);
    stg_nxt[0].v.neg = p1_r.negv;
    stg_nxt[0].w.rem = numw;
    stg_nxt[0].w.q   = '0;
    stg_nxt[0].w.sat = (numw >= dlim);
    stg_nxt[0].w.neg = p1_r.negw;
    for (int k = 1; k <= QB; k++) begin
      shd[k] = CMPW'(stg_r[k-1].den) << (QB - k);
      stg_nxt[k] = stg_r[k-1];
      if (stg_r[k-1].v.rem >= shd[k]) begin
        stg_nxt[k].v.rem = stg_r[k-1].v.rem - shd[k];
        stg_nxt[k].v.q[QB-k] = 1'b1;
      end
      if (stg_r[k-1].w.rem >= shd[k]) begin
        stg_nxt[k].w.rem = stg_r[k-1].w.rem - shd[k];
        stg_nxt[k].w.q[QB-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      for (int k = 0; k <= QB; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_valid;
      vld_r[0] <= p1_vld_r;
      for (int k = 1; k <= QB; k++) vld_r[k] <= vld_r[k-1];
    end
    if (en) begin
      p1_r <= p1_nxt;
      for (int k = 0; k <= QB; k++) stg_r[k] <= stg_nxt[k];
    end
  end

  assign out_valid     = vld_r[QB];
  assign out_data.qv   = stg_r[QB].v.q;
  assign out_data.qw   = stg_r[QB].w.q;
  assign out_data.satv = stg_r[QB].v.sat;
  assign out_data.satw = stg_r[QB].w.sat;
  assign out_data.negv = stg_r[QB].v.neg;
  assign out_data.negw = stg_r[QB].w.neg;
  assign out_data.side = stg_r[QB].side;

  a_rem_v: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB] && !stg_r[QB].v.sat |-> stg_r[QB].v.rem < CMPW'(stg_r[QB].den))
    else $error("v remainder not below divisor");
  a_rem_w: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB] && !stg_r[QB].w.sat |-> stg_r[QB].w.rem < CMPW'(stg_r[QB].den))
    else $error("w remainder not below divisor");

endmodule

// ===== src/thi_blend.sv =====
// Weight signing, third weight, height products and final rounding with saturation; degenerate gives zero.
// Depends on thi_pkg; four register stages, the last one is the output register.
module thi_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  thi_pkg::div_out_t in_data,
  output logic              out_valid,
  output logic              out_inside,
  output logic              out_degen,
  output thi_pkg::coord_t   out_height
);
  import thi_pkg::*;

  typedef logic signed [WGTW-1:0] wgt_t;
  typedef logic signed [UW-1:0]   uwt_t;
  typedef logic signed [PRW-1:0]  prw_t;

  typedef struct packed {
    wgt_t  v, w;
    side_t side;
  } b1_t;

  typedef struct packed {
    uwt_t  u, v, w;
    side_t side;
  } b2_t;

  typedef struct packed {
    prw_t  pa, pb, pc;
    side_t side;
  } b3_t;

  logic [3:0] vld_r;
  b1_t    b1_r, b1_nxt;
  b2_t    b2_r, b2_nxt;
  b3_t    b3_r, b3_nxt;
  logic   ins_r, deg_r;
  coord_t hgt_r, hgt_nxt;

  logic [QB-1:0] mv, mw;
  logic signed [ACCW-1:0] acc;
  logic signed [RW-1:0]   rnd;
  localparam logic signed [RW-1:0] HMAX = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] HMIN = -HMAX - RW'(1);

  always_comb begin
    mv = in_data.satv ? WEIGHT_MAX : in_data.qv;
    mw = in_data.satw ? WEIGHT_MAX : in_data.qw;
    b1_nxt.v = in_data.negv ? -wgt_t'({1'b0, mv}) : wgt_t'({1'b0, mv});
    b1_nxt.w = in_data.negw ? -wgt_t'({1'b0, mw}) : wgt_t'({1'b0, mw});
    b1_nxt.side = in_data.side;

    b2_nxt.v = UW'(b1_r.v);
    b2_nxt.w = UW'(b1_r.w);
    b2_nxt.u = (uwt_t'(1) <<< WF) - UW'(b1_r.v) - UW'(b1_r.w);
    b2_nxt.side = b1_r.side;

    b3_nxt.pa = PRW'(b2_r.side.h0) * PRW'(b2_r.u);
    b3_nxt.pb = PRW'(b2_r.side.h1) * PRW'(b2_r.v);
    b3_nxt.pc = PRW'(b2_r.side.h2) * PRW'(b2_r.w);
    b3_nxt.side = b2_r.side;

    acc = ACCW'(b3_r.pa) + ACCW'(b3_r.pb) + ACCW'(b3_r.pc)
        + (ACCW'(1) <<< (WF - 1));
    rnd = RW'(acc >>> WF);
    if (b3_r.side.degen) begin
      hgt_nxt = '0;
    end else if (rnd > HMAX) begin
      hgt_nxt = HMAX[COORD_WIDTH-1:0];
    end else if (rnd < HMIN) begin
      hgt_nxt = HMIN[COORD_WIDTH-1:0];
    end else begin
      hgt_nxt = rnd[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
    if (en) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      hgt_r <= hgt_nxt;
      ins_r <= b3_r.side.hit;
      deg_r <= b3_r.side.degen;
    end
  end

  assign out_valid  = vld_r[3];
  assign out_inside = ins_r;
  assign out_degen  = deg_r;
  assign out_height = hgt_r;

  a_rst: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

endmodule
